### design/swmm_pkg.sv
// Shared constants, types and helper functions of the sliding window mex unit.
package swmm_pkg;

    localparam int VALUE_W     = 10;
    localparam int VALUES      = 1 << VALUE_W;
    localparam int WINDOW_MAX  = 1024;
    localparam int PTR_W       = $clog2(WINDOW_MAX);
    localparam int LEN_W       = 11;
    localparam int CNT_W       = 11;
    localparam int MEX_W       = 11;
    localparam int BIT_W       = 5;
    localparam int WORD_W      = 1 << BIT_W;
    localparam int WADDR_W     = VALUE_W - BIT_W;
    localparam int WORDS       = VALUES / WORD_W;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - 2 * MEX_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [MEX_W-1:0] MEX_NONE = MEX_W'(VALUES);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               eos;
        logic               has_result;
        logic [PTR_W-1:0]   slot;
        logic [PTR_W-1:0]   old_slot;
    } swmm_item_t;

    typedef struct packed {
        logic       valid;
        swmm_item_t item;
    } swmm_head_t;

    function automatic logic [BIT_W-1:0] first_set(input logic [WORD_W-1:0] v);
        logic [BIT_W-1:0] idx;
        idx = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            if (v[i])
            begin
                idx = BIT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

### design/swmm_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module swmm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/swmm_front.sv
// Front end: window length register, item classification and the item queue.
module swmm_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [swmm_pkg::LEN_W-1:0]      cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [swmm_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                            s_tlast,
    input  logic                            clearing,
    input  logic                            pop,
    output swmm_pkg::swmm_head_t            head
);

    import swmm_pkg::*;

    logic [LEN_W-1:0]  cfg_reg, cfg_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;
    swmm_item_t        queue_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_reg, wr_next;
    logic [QPTR_W-1:0] rd_reg, rd_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    logic [LEN_W-1:0]  wlen;
    logic [LEN_W-1:0]  fill_inc;
    logic              accept;
    swmm_item_t        new_item;

    always_comb
    begin
        if (cfg_reg == '0)
        begin
            wlen = LEN_W'(1);
        end
        else if (cfg_reg > LEN_W'(WINDOW_MAX))
        begin
            wlen = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            wlen = cfg_reg;
        end
    end

    assign fill_inc = (fill_reg < wlen) ? LEN_W'(fill_reg + LEN_W'(1)) : fill_reg;
    assign s_tready = (count_reg != QCNT_W'(QUEUE_DEPTH)) && !clearing;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        new_item.value      = s_tdata[VALUE_W-1:0];
        new_item.eos        = s_tlast;
        new_item.has_result = (fill_inc == wlen);
        new_item.slot       = ptr_reg;
        new_item.old_slot   = PTR_W'(ptr_reg - PTR_W'(wlen - LEN_W'(1)));
    end

    always_comb
    begin
        cfg_next   = cfg_reg;
        fill_next  = fill_reg;
        ptr_next   = ptr_reg;
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        count_next = count_reg;
        if (cfg_we)
        begin
            cfg_next   = cfg_data;
            fill_next  = '0;
            ptr_next   = '0;
            wr_next    = '0;
            rd_next    = '0;
            count_next = '0;
        end
        else
        begin
            if (accept)
            begin
                fill_next = new_item.has_result ? LEN_W'(wlen - LEN_W'(1)) : fill_inc;
                ptr_next  = PTR_W'(ptr_reg + PTR_W'(1));
                wr_next   = QPTR_W'(wr_reg + QPTR_W'(1));
            end
            if (pop)
            begin
                rd_next = QPTR_W'(rd_reg + QPTR_W'(1));
            end
            if (accept && !pop)
            begin
                count_next = QCNT_W'(count_reg + QCNT_W'(1));
            end
            else if (pop && !accept)
            begin
                count_next = QCNT_W'(count_reg - QCNT_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg   <= LEN_W'(1);
            fill_reg  <= '0;
            ptr_reg   <= '0;
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            cfg_reg   <= cfg_next;
            fill_reg  <= fill_next;
            ptr_reg   <= ptr_next;
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && !cfg_we)
        begin
            queue_reg[wr_reg] <= new_item;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = queue_reg[rd_reg];

endmodule

### design/swmm_back.sv
// Back end: count and absent-map updates, first-zero search and the result register.
module swmm_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  swmm_pkg::swmm_head_t             head,
    output logic                             pop,
    output logic                             clearing,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [swmm_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                             m_tlast
);

    import swmm_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD,
        ST_MEX_RD,
        ST_MEX,
        ST_DEL
    } state_t;

    state_t             state_reg, state_next;
    swmm_item_t         item_reg, item_next;
    logic [BIT_W-1:0]   sidx_reg, sidx_next;
    logic               sany_reg, sany_next;
    logic [MEX_W-1:0]   mex_reg, mex_next;
    logic [VALUE_W-1:0] old_reg, old_next;
    logic [WORDS-1:0]   summary_reg, summary_next;
    logic [VALUE_W-1:0] clr_reg, clr_next;
    logic [MEX_W-1:0]   best_reg, best_next;
    logic               out_valid_reg, out_valid_next;
    logic [MEX_W-1:0]   out_mex_reg, out_mex_next;
    logic [MEX_W-1:0]   out_min_reg, out_min_next;
    logic               out_last_reg, out_last_next;

    logic               cnt_we;
    logic [VALUE_W-1:0] cnt_waddr;
    logic [CNT_W-1:0]   cnt_wdata;
    logic [VALUE_W-1:0] cnt_raddr;
    logic [CNT_W-1:0]   cnt_rdata;
    logic               abs_we;
    logic [WADDR_W-1:0] abs_waddr;
    logic [WORD_W-1:0]  abs_wdata;
    logic [WADDR_W-1:0] abs_raddr;
    logic [WORD_W-1:0]  abs_rdata;
    logic               ring_we;
    logic [PTR_W-1:0]   ring_waddr;
    logic [VALUE_W-1:0] ring_wdata;
    logic [PTR_W-1:0]   ring_raddr;
    logic [VALUE_W-1:0] ring_rdata;

    logic [WORD_W-1:0]  bit_mask;
    logic [CNT_W-1:0]   dec_count;
    logic [MEX_W-1:0]   new_best;

    swmm_ram #(.WIDTH(CNT_W), .DEPTH(VALUES)) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    swmm_ram #(.WIDTH(WORD_W), .DEPTH(WORDS)) u_absent_ram (
        .clk   (clk),
        .we    (abs_we),
        .waddr (abs_waddr),
        .wdata (abs_wdata),
        .raddr (abs_raddr),
        .rdata (abs_rdata)
    );

    swmm_ram #(.WIDTH(VALUE_W), .DEPTH(WINDOW_MAX)) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    assign dec_count = (cnt_rdata == '0) ? '0 : CNT_W'(cnt_rdata - CNT_W'(1));
    assign new_best  = (mex_reg < best_reg) ? mex_reg : best_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        sidx_next      = sidx_reg;
        sany_next      = sany_reg;
        mex_next       = mex_reg;
        old_next       = old_reg;
        summary_next   = summary_reg;
        clr_next       = clr_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg;
        out_mex_next   = out_mex_reg;
        out_min_next   = out_min_reg;
        out_last_next  = out_last_reg;

        pop        = 1'b0;
        cnt_we     = 1'b0;
        cnt_waddr  = item_reg.value;
        cnt_wdata  = '0;
        cnt_raddr  = head.item.value;
        abs_we     = 1'b0;
        abs_waddr  = item_reg.value[VALUE_W-1:BIT_W];
        abs_wdata  = '0;
        abs_raddr  = head.item.value[VALUE_W-1:BIT_W];
        ring_we    = 1'b0;
        ring_waddr = head.item.slot;
        ring_wdata = head.item.value;
        ring_raddr = item_reg.old_slot;
        bit_mask   = WORD_W'(1) << item_reg.value[BIT_W-1:0];

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            state_next   = ST_CLEAR;
            clr_next     = '0;
            summary_next = '1;
        end
        else
        begin
            case (state_reg)
                ST_CLEAR:
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = clr_reg;
                    cnt_wdata = '0;
                    abs_we    = 1'b1;
                    abs_waddr = clr_reg[VALUE_W-1:BIT_W];
                    abs_wdata = '1;
                    clr_next  = VALUE_W'(clr_reg + VALUE_W'(1));
                    if (clr_reg == '1)
                    begin
                        state_next = ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (head.valid)
                    begin
                        pop        = 1'b1;
                        item_next  = head.item;
                        ring_we    = 1'b1;
                        state_next = ST_ADD;
                    end
                end
                ST_ADD:
                begin
                    cnt_we    = 1'b1;
                    cnt_wdata = CNT_W'(cnt_rdata + CNT_W'(1));
                    abs_we    = 1'b1;
                    abs_wdata = abs_rdata & ~bit_mask;
                    summary_next[item_reg.value[VALUE_W-1:BIT_W]] = |(abs_rdata & ~bit_mask);
                    state_next = item_reg.has_result ? ST_MEX_RD : ST_IDLE;
                end
                ST_MEX_RD:
                begin
                    sidx_next  = first_set(summary_reg);
                    sany_next  = |summary_reg;
                    abs_raddr  = first_set(summary_reg);
                    ring_raddr = item_reg.old_slot;
                    state_next = ST_MEX;
                end
                ST_MEX:
                begin
                    mex_next   = sany_reg ? {1'b0, sidx_reg, first_set(abs_rdata)} : MEX_NONE;
                    old_next   = ring_rdata;
                    cnt_raddr  = ring_rdata;
                    abs_raddr  = ring_rdata[VALUE_W-1:BIT_W];
                    state_next = ST_DEL;
                end
                ST_DEL:
                begin
                    cnt_raddr = old_reg;
                    abs_raddr = old_reg[VALUE_W-1:BIT_W];
                    cnt_waddr = old_reg;
                    abs_waddr = old_reg[VALUE_W-1:BIT_W];
                    bit_mask  = WORD_W'(1) << old_reg[BIT_W-1:0];
                    if (!out_valid_reg || m_tready)
                    begin
                        cnt_we    = 1'b1;
                        cnt_wdata = dec_count;
                        if (dec_count == '0)
                        begin
                            abs_we    = 1'b1;
                            abs_wdata = abs_rdata | bit_mask;
                            summary_next[old_reg[VALUE_W-1:BIT_W]] = 1'b1;
                        end
                        best_next      = new_best;
                        out_valid_next = 1'b1;
                        out_mex_next   = mex_reg;
                        out_min_next   = new_best;
                        out_last_next  = item_reg.eos;
                        state_next     = ST_IDLE;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            item_reg      <= '0;
            sidx_reg      <= '0;
            sany_reg      <= 1'b0;
            mex_reg       <= '0;
            old_reg       <= '0;
            summary_reg   <= '1;
            clr_reg       <= '0;
            best_reg      <= MEX_NONE;
            out_valid_reg <= 1'b0;
            out_mex_reg   <= '0;
            out_min_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            item_reg      <= item_next;
            sidx_reg      <= sidx_next;
            sany_reg      <= sany_next;
            mex_reg       <= mex_next;
            old_reg       <= old_next;
            summary_reg   <= summary_next;
            clr_reg       <= clr_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
            out_mex_reg   <= out_mex_next;
            out_min_reg   <= out_min_next;
            out_last_reg  <= out_last_next;
        end
    end

    assign clearing = (state_reg == ST_CLEAR);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_min_reg, out_mex_reg};
    assign m_tlast  = out_last_reg;

endmodule

### design/sliding_window_mex_min_unit.sv
// Top level of the sliding window mex unit: front end, item queue and back end.
// An item that completes a window passes through the back-end states IDLE, ADD, MEX_RD,
// MEX and DEL before its result shows on m_tvalid; DEL waits while a result stalls.
// An item that does not complete a window passes through IDLE and ADD only.
// These states do the count and absent-map read-modify-write and the two-level first-zero search.
// After reset and every window_len write, clearing all count entries holds s_tready low.
module sliding_window_mex_min_unit (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [swmm_pkg::LEN_W-1:0]       cfg_data,    // window_len
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [swmm_pkg::IN_TDATA_W-1:0]  s_tdata,     // value
    input  logic                             s_tlast,     // end_of_stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [swmm_pkg::OUT_TDATA_W-1:0] m_tdata,     // window_mex, running_min
    output logic                             m_tlast      // final_res
);

    import swmm_pkg::*;

    swmm_head_t head;
    logic       pop;
    logic       clearing;

    swmm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .clearing (clearing),
        .pop      (pop),
        .head     (head)
    );

    swmm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .head     (head),
        .pop      (pop),
        .clearing (clearing),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

### design/swmm_checker.sv
// Port-level checker for the sliding window mex unit and its bind statement.
module swmm_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             cfg_we,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [swmm_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                             m_tlast
);

    import swmm_pkg::*;

    logic [MEX_W-1:0] last_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_min_reg <= MEX_NONE;
        end
        else if (m_tvalid && m_tready)
        begin
            last_min_reg <= m_tdata[2*MEX_W-1:MEX_W];
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Stalled result beat changed.");

    a_min_le_mex: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2*MEX_W-1:MEX_W] <= m_tdata[MEX_W-1:0])
        else $error("Running minimum exceeds the window mex.");

    a_min_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[2*MEX_W-1:MEX_W] <= last_min_reg)
        else $error("Running minimum increased.");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !m_tvalid && !s_tready)
        else $error("Handshake active during reset.");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_tready)
        else $error("Input accepted right after a window length write.");

endmodule

bind sliding_window_mex_min_unit swmm_checker u_checker (.*);

### bench/sliding_window_mex_min_unit_tb.sv
// Testbench for sliding_window_mex_min_unit: directed and random streaming traffic checked by a scoreboard.
`timescale 1ns / 1ps

module sliding_window_mex_min_unit_tb;

    import swmm_pkg::*;

    localparam int DRAIN_CYCLES = 24;
    localparam int LONG_HOLD    = 400;
    localparam int RANDOM_ITEMS = 840;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [LEN_W-1:0]       cfg_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    typedef struct packed {
        logic [MEX_W-1:0] mex;
        logic [MEX_W-1:0] run_min;
        logic             is_final;
    } mex_result_t;

    class mex_scoreboard;
        logic [CNT_W-1:0]   counts [VALUES];
        logic [VALUE_W-1:0] ring [WINDOW_MAX];
        int unsigned        ptr;
        int unsigned        fill;
        int unsigned        span;
        int unsigned        best;
        mex_result_t        mex_queue [$];
        int                 errors;
        int                 values_taken;
        int                 results_seen;

        function new();
            foreach (ring[i])
                ring[i] = '0;
            best = VALUES;
            errors = 0;
            values_taken = 0;
            results_seen = 0;
            set_window(LEN_W'(1));
        endfunction

        function void set_window(logic [LEN_W-1:0] len);
            if (len == 0)
                span = 1;
            else if (len > WINDOW_MAX)
                span = WINDOW_MAX;
            else
                span = len;
            foreach (counts[i])
                counts[i] = '0;
            ptr = 0;
            fill = 0;
        endfunction

        function void add_value(logic [VALUE_W-1:0] v, logic eos);
            mex_result_t        r;
            int unsigned        mex;
            int unsigned        old_slot;
            logic [VALUE_W-1:0] old;
            values_taken++;
            ring[ptr] = v;
            counts[v] = counts[v] + 1'b1;
            if (fill < span)
                fill++;
            if (fill < span)
            begin
                ptr = (ptr + 1) % WINDOW_MAX;
                return;
            end
            mex = VALUES;
            for (int i = 0; i < VALUES; i++)
            begin
                if (counts[i] == 0)
                begin
                    mex = i;
                    break;
                end
            end
            if (mex < best)
                best = mex;
            r.mex = MEX_W'(mex);
            r.run_min = MEX_W'(best);
            r.is_final = eos;
            mex_queue = {mex_queue, r};
            old_slot = (ptr + WINDOW_MAX - (span - 1)) % WINDOW_MAX;
            old = ring[old_slot];
            if (counts[old] != 0)
                counts[old] = counts[old] - 1'b1;
            fill = span - 1;
            ptr = (ptr + 1) % WINDOW_MAX;
        endfunction

        function void report(string what, int want, int got);
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic tl);
            mex_result_t      want;
            logic [MEX_W-1:0] got_mex;
            logic [MEX_W-1:0] got_min;
            got_mex = data[MEX_W-1:0];
            got_min = data[2*MEX_W-1:MEX_W];
            results_seen++;
            if (mex_queue.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual mex %0d min %0d final %0b",
                         $time, got_mex, got_min, tl);
                return;
            end
            want = mex_queue.pop_front();
            if (got_mex != want.mex)
                report("window_mex", want.mex, got_mex);
            if (got_min != want.run_min)
                report("running_min", want.run_min, got_min);
            if (tl != want.is_final)
                report("final_res", want.is_final, tl);
        endfunction

        function int pending();
            return mex_queue.size();
        endfunction
    endclass

    mex_scoreboard      sb;
    int                 burst_left;
    int                 settings;
    bit                 hold_request;

    sliding_window_mex_min_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("Run did not finish in time, %0d results still expected.", sb.pending());
        $display("[sliding_window_mex_min_unit] ERROR");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    initial
    begin : rx_side
        int seg;
        int mode;
        int hold_left;
        seg = 0;
        mode = 0;
        hold_left = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                if (seg == 0)
                begin
                    seg = $urandom_range(8, 64);
                    mode = $urandom_range(0, 3);
                end
                seg--;
                if (mode == 0)
                    m_tready <= 1'b1;
                else if (mode == 1)
                    m_tready <= 1'($urandom_range(0, 1));
                else if (mode == 2)
                    m_tready <= ($urandom_range(0, 3) == 0);
                else
                    m_tready <= ((seg % 5) < 2);
            end
        end
    end

    function automatic logic [VALUE_W-1:0] pick_value(int span);
        if ($urandom_range(0, 4) == 0)
            return VALUE_W'($urandom);
        return VALUE_W'($urandom_range(0, span + 1));
    endfunction

    task automatic push_value(input logic [VALUE_W-1:0] v, input logic eos);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tdata <= IN_TDATA_W'(v);
        s_tlast <= eos;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.add_value(v, eos);
    endtask

    task automatic write_window(input logic [LEN_W-1:0] len);
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_data <= len;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_window(len);
        settings++;
    endtask

    initial
    begin
        int                 n;
        int                 span;
        int                 pick;
        int                 rand_items;
        int                 phase;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        hold_request = 1'b0;
        burst_left = 0;
        settings = 0;
        sb = new();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // A saturated window does not fill within these beats, so no result may appear.
        write_window({LEN_W{1'b1}});
        for (int i = 0; i < 40; i++)
            push_value(pick_value(4), i == 39);

        write_window('0);
        push_value(10'd0, 1'b0);
        push_value(10'd0, 1'b1);
        push_value(10'd1023, 1'b0);
        push_value(10'd1, 1'b0);
        push_value(10'd512, 1'b1);

        write_window(LEN_W'(3));
        push_value(10'd0, 1'b0);
        push_value(10'd1, 1'b1);
        push_value(10'd2, 1'b0);
        push_value(10'd2, 1'b0);
        push_value(10'd0, 1'b0);
        push_value(10'd1, 1'b0);
        push_value(10'd1023, 1'b0);
        push_value(10'd0, 1'b1);

        write_window(LEN_W'(1));
        push_value(10'd1, 1'b0);
        push_value(10'd0, 1'b0);
        push_value(10'd682, 1'b0);
        push_value(10'd341, 1'b1);

        rand_items = 0;
        phase = 0;
        while (rand_items < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 6)
                span = $urandom_range(1, 4);
            else if (pick < 8)
                span = $urandom_range(5, 12);
            else if (pick == 8)
                span = 32;
            else
                span = $urandom_range(60, 200);
            if (phase == 0)
                span = 2;
            write_window(LEN_W'(span));
            if (phase == 0)
                hold_request = 1'b1;
            n = $urandom_range(40, 120) + span;
            for (int k = 0; k < n; k++)
                push_value(pick_value(span), $urandom_range(0, 15) == 0);
            rand_items += n;
            phase++;
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d values under %0d window settings and checked %0d results.",
                 sb.values_taken, settings, sb.results_seen);
        $display("Settings ranged from zero to a saturated full window; %0d mismatches.", sb.errors);
        if (sb.errors == 0)
            $display("[sliding_window_mex_min_unit] OK");
        else
            $display("[sliding_window_mex_min_unit] ERROR");
        $finish;
    end

endmodule

### sim.f
design/swmm_pkg.sv
design/swmm_ram.sv
design/swmm_front.sv
design/swmm_back.sv
design/sliding_window_mex_min_unit.sv
design/swmm_checker.sv
bench/sliding_window_mex_min_unit_tb.sv
